@@ sv/lsa_pkg.sv @@
// lsa_pkg: shared types, constants and tables for the log-softmax argmax scorer
// used by lsa_mul, log_softmax_argmax_scorer and lsa_check; no dependencies
package lsa_pkg;

  // default parameter values
  localparam int unsigned MaxVocabDef     = 262144;
  localparam int unsigned LogitFracBitsDef = 16;

  // field widths fixed by the interface
  localparam int unsigned LogitW = 24;
  localparam int unsigned IndexW = 18;
  localparam int unsigned SumW   = 36;

  // shared multiplier operand and product widths
  localparam int unsigned MulAW = 36;
  localparam int unsigned MulBW = 32;
  localparam int unsigned MulPW = MulAW + MulBW;

  // fixed-point constants
  localparam logic [SumW-1:0]   OneQ18   = 36'd262144;
  localparam logic [SumW-1:0]   SumMax   = 36'hF_FFFF_FFFF;
  localparam logic [16:0]       Log2eQ16 = 17'd94548;
  localparam logic [15:0]       Ln2Q16   = 16'd45426;
  localparam logic [LogitW-1:0] LpMin    = 24'h800000;

  // input beat
  typedef struct packed {
    logic signed [LogitW-1:0] logit_value;
    logic [IndexW-1:0]        target_index;
    logic                     last_logit;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic signed [LogitW-1:0] log_prob;
    logic [IndexW-1:0]        greedy_index;
    logic                     target_found;
  } out_beat_t;

  // 2^(-i/16) in Q.18, i = 0..16
  function automatic logic [18:0] pow2_frac(input logic [4:0] idx);
    logic [18:0] val;
    case (idx)
      5'd0:    val = 19'd262144;
      5'd1:    val = 19'd251030;
      5'd2:    val = 19'd240387;
      5'd3:    val = 19'd230195;
      5'd4:    val = 19'd220436;
      5'd5:    val = 19'd211090;
      5'd6:    val = 19'd202141;
      5'd7:    val = 19'd193571;
      5'd8:    val = 19'd185364;
      5'd9:    val = 19'd177505;
      5'd10:   val = 19'd169979;
      5'd11:   val = 19'd162773;
      5'd12:   val = 19'd155872;
      5'd13:   val = 19'd149263;
      5'd14:   val = 19'd142935;
      5'd15:   val = 19'd136875;
      default: val = 19'd131072;
    endcase
    return val;
  endfunction

endpackage

@@ sv/lsa_mul.sv @@
// lsa_mul: shared unsigned multiplier with a registered product
// depends on lsa_pkg
module lsa_mul (
  input  logic                    clk_i,
  input  logic [lsa_pkg::MulAW-1:0] a_i,
  input  logic [lsa_pkg::MulBW-1:0] b_i,
  output logic [lsa_pkg::MulPW-1:0] p_o
);
  import lsa_pkg::*;

  logic [MulPW-1:0] p_q;

  // one product per cycle, registered so the result appears in the next cycle
  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ sv/log_softmax_argmax_scorer.sv @@
// Log-softmax scorer with greedy argmax. Logits arrive one per input beat (signed
// Q(24-F).F, F = LOGIT_FRAC_BITS); the beat flagged last_logit ends the vector and yields
// one result beat with the target's log-probability (saturated to [-2^23, 0]), the index
// of the first maximum and a found flag. Each element keeps the block busy, longer when
// it is a new maximum and shorter for the first element of a vector: every step of the
// exponential and the sum rescale goes through one shared registered multiplier. The last
// element adds the logarithm (setup, 16 squarings each with a reduction step, the ln 2
// scaling and the hand-over to the output register), or only the hand-over when the target
// is absent. A finished result sits in an output register, so the next vector may start
// while it waits; a second result waits in the sequencer until the first one has left.
// depends on lsa_pkg and lsa_mul
module log_softmax_argmax_scorer #(
  parameter int unsigned MAX_VOCAB       = lsa_pkg::MaxVocabDef,
  parameter int unsigned LOGIT_FRAC_BITS = lsa_pkg::LogitFracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lsa_pkg::in_beat_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lsa_pkg::out_beat_t out_data_o
);
  import lsa_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_VOCAB + 1);
  localparam int unsigned Shl  = (LOGIT_FRAC_BITS >= 16) ? LOGIT_FRAC_BITS - 16 : 0;
  localparam int unsigned Shr  = (LOGIT_FRAC_BITS < 16) ? 16 - LOGIT_FRAC_BITS : 0;

  typedef enum logic [3:0] {
    S_IDLE, S_EXPU, S_EXPI, S_EXPS, S_SCALE, S_CHECK,
    S_LN0, S_SQ, S_SQR, S_LNM, S_LNR, S_OUT
  } state_e;

  state_e state_q;

  logic signed [LogitW-1:0] max_q;
  logic [IndexW-1:0]        best_q;
  logic [SumW-1:0]          sum_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [LogitW-1:0] tgt_logit_q;
  logic                     seen_q;
  logic                     last_q;
  logic                     newmax_q;
  logic [23:0]              m_q;
  logic [18:0]              a_q;
  logic [4:0]               k_q;
  logic                     kbig_q;
  logic [30:0]              y_q;
  logic [4:0]               ip_q;
  logic [15:0]              frac_q;
  logic [3:0]               j_q;
  logic [LogitW-1:0]        lp_q;
  logic                     out_valid_q;
  out_beat_t                out_q;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;

  lsa_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // accept-side compare and distance to the running maximum
  logic                     in_acc;
  logic signed [LogitW:0]   dx;
  logic signed [LogitW:0]   ndx;
  logic                     gt;
  logic                     cnt_ok;
  logic                     tgt_hit;

  always_comb begin
    in_acc  = in_valid_i && (state_q == S_IDLE);
    dx      = {in_data_i.logit_value[LogitW-1], in_data_i.logit_value} -
              {max_q[LogitW-1], max_q};
    ndx     = -dx;
    gt      = in_data_i.logit_value > max_q;
    cnt_ok  = cnt_q < CntW'(MAX_VOCAB);
    tgt_hit = 32'(cnt_q) == 32'(in_data_i.target_index);
  end

  // exponential: exponent split and table interpolation
  logic [MulPW-1:0] u_full;
  logic [MulPW-1:0] k_full;
  logic [15:0]      f_u;
  logic [18:0]      ta;
  logic [18:0]      tb;
  logic [18:0]      tdiff;

  always_comb begin
    u_full = (mul_p + (MulPW'(1) << (LOGIT_FRAC_BITS - 1))) >> LOGIT_FRAC_BITS;
    k_full = u_full >> 16;
    f_u    = u_full[15:0];
    ta     = pow2_frac({1'b0, f_u[15:12]});
    tb     = pow2_frac(5'({1'b0, f_u[15:12]} + 5'd1));
    tdiff  = ta - tb;
  end

  // exponential: interpolated value and rounded shift by k
  logic [18:0] v_e;
  logic [19:0] sh_e;
  logic [18:0] e_val;
  logic [SumW:0] add_sum;
  logic [MulPW-1:0] scl;

  always_comb begin
    v_e  = a_q - 19'((mul_p + MulPW'(2048)) >> 12);
    sh_e = (20'(v_e) + (20'(1) << (k_q - 5'd1))) >> k_q;
    if (kbig_q) begin
      e_val = '0;
    end else if (k_q == 5'd0) begin
      e_val = v_e;
    end else begin
      e_val = sh_e[18:0];
    end
    add_sum = {1'b0, sum_q} + (SumW + 1)'(e_val);
    scl     = ((mul_p + (MulPW'(1) << 17)) >> 18) + MulPW'(OneQ18);
  end

  // logarithm setup: leading one and mantissa normalisation
  logic [SumW-1:0] s_ln;
  logic [5:0]      lead;
  logic [30:0]     y_norm;
  logic [31:0]     yy;

  always_comb begin
    s_ln = (sum_q < OneQ18) ? OneQ18 : sum_q;
    lead = '0;
    for (int b = 0; b < SumW; b++) begin
      if (s_ln[b]) begin
        lead = 6'(b);
      end
    end
    if (lead >= 6'd30) begin
      y_norm = 31'(s_ln >> (lead - 6'd30));
    end else begin
      y_norm = 31'(s_ln << (6'd30 - lead));
    end
    yy = mul_p[61:30];
  end

  // ln scaling to the logit format and final saturation
  logic [MulPW-1:0]  ln0;
  logic [31:0]       ln_f;
  logic signed [33:0] lp_w;
  logic [LogitW-1:0] lp_sat;

  always_comb begin
    ln0 = (mul_p + MulPW'(32768)) >> 16;
    if (LOGIT_FRAC_BITS >= 16) begin
      ln_f = 32'(ln0 << Shl);
    end else begin
      ln_f = 32'((ln0 + (MulPW'(1) << (Shr - 1))) >> Shr);
    end
    lp_w = 34'(tgt_logit_q) - 34'(max_q) - $signed({2'b00, ln_f});
    if (lp_w < -34'sd8388608) begin
      lp_sat = LpMin;
    end else if (lp_w > 34'sd0) begin
      lp_sat = '0;
    end else begin
      lp_sat = lp_w[LogitW-1:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_EXPU: begin
        mul_a = MulAW'(m_q);
        mul_b = MulBW'(Log2eQ16);
      end
      S_EXPI: begin
        mul_a = MulAW'(tdiff);
        mul_b = MulBW'(f_u[11:0]);
      end
      S_EXPS: begin
        mul_a = sum_q;
        mul_b = MulBW'(e_val);
      end
      S_SQ: begin
        mul_a = MulAW'(y_q);
        mul_b = MulBW'(y_q);
      end
      S_LNM: begin
        mul_a = MulAW'({ip_q, frac_q});
        mul_b = MulBW'(Ln2Q16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // result hand-over into the output register
  logic out_fire;

  assign out_fire = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // sequencer, vector state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_q       <= '0;
      best_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      tgt_logit_q <= '0;
      seen_q      <= 1'b0;
      last_q      <= 1'b0;
      newmax_q    <= 1'b0;
      m_q         <= '0;
      a_q         <= '0;
      k_q         <= '0;
      kbig_q      <= 1'b0;
      y_q         <= '0;
      ip_q        <= '0;
      frac_q      <= '0;
      j_q         <= '0;
      lp_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            last_q <= in_data_i.last_logit;
            if (cnt_ok && cnt_q != '0) begin
              state_q <= S_EXPU;
            end else begin
              state_q <= S_CHECK;
            end
            if (cnt_ok) begin
              cnt_q <= cnt_q + CntW'(1);
              if (tgt_hit) begin
                tgt_logit_q <= in_data_i.logit_value;
                seen_q      <= 1'b1;
              end
              if (cnt_q == '0) begin
                max_q  <= in_data_i.logit_value;
                best_q <= '0;
                sum_q  <= OneQ18;
              end else begin
                newmax_q <= gt;
                m_q      <= gt ? dx[LogitW-1:0] : ndx[LogitW-1:0];
                if (gt) begin
                  max_q  <= in_data_i.logit_value;
                  best_q <= IndexW'(cnt_q);
                end
              end
            end
          end
        end
        S_EXPU: begin
          state_q <= S_EXPI;
        end
        S_EXPI: begin
          a_q     <= ta;
          k_q     <= 5'(k_full);
          kbig_q  <= k_full >= MulPW'(20);
          state_q <= S_EXPS;
        end
        S_EXPS: begin
          if (newmax_q) begin
            state_q <= S_SCALE;
          end else begin
            sum_q   <= add_sum[SumW] ? SumMax : add_sum[SumW-1:0];
            state_q <= S_CHECK;
          end
        end
        S_SCALE: begin
          sum_q   <= (scl > MulPW'(SumMax)) ? SumMax : scl[SumW-1:0];
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (seen_q && cnt_q != '0) begin
            state_q <= S_LN0;
          end else begin
            lp_q    <= LpMin;
            state_q <= S_OUT;
          end
        end
        S_LN0: begin
          y_q     <= y_norm;
          ip_q    <= 5'(lead - 6'd18);
          frac_q  <= '0;
          j_q     <= 4'd15;
          state_q <= S_SQ;
        end
        S_SQ: begin
          state_q <= S_SQR;
        end
        S_SQR: begin
          if (yy[31]) begin
            frac_q[j_q] <= 1'b1;
            y_q         <= yy[31:1];
          end else begin
            y_q <= yy[30:0];
          end
          if (j_q == 4'd0) begin
            state_q <= S_LNM;
          end else begin
            j_q     <= j_q - 4'd1;
            state_q <= S_SQ;
          end
        end
        S_LNM: begin
          state_q <= S_LNR;
        end
        S_LNR: begin
          lp_q    <= lp_sat;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            out_q.log_prob        <= lp_q;
            out_q.greedy_index    <= best_q;
            out_q.target_found    <= seen_q;
            max_q                 <= '0;
            best_q                <= '0;
            sum_q                 <= '0;
            cnt_q                 <= '0;
            tgt_logit_q           <= '0;
            seen_q                <= 1'b0;
            state_q               <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/lsa_check.sv @@
// lsa_check: port-level assertions for log_softmax_argmax_scorer, bound to the top level
// depends on lsa_pkg
module lsa_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lsa_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lsa_pkg::out_beat_t out_data_o
);
  import lsa_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed under stall");

  // an accepted element keeps the block busy the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block ready straight after an accepted beat");

  // a missing target gives the lowest log-probability
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.target_found |-> out_data_o.log_prob == LpMin)
    else $error("absent target without lowest log-probability");

  // log-probability never positive
  a_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.log_prob[LogitW-1] || out_data_o.log_prob == '0)
    else $error("positive log-probability");

endmodule

bind log_softmax_argmax_scorer lsa_check u_lsa_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ test/lsa_check.sv @@
// lsa_score_check: watches both channels of the log-softmax argmax scorer, predicts each
// result beat from the accepted input beats and compares field by field
// depends on lsa_pkg
module lsa_score_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  lsa_pkg::in_beat_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  lsa_pkg::out_beat_t out_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lsa_pkg::*;

  localparam int unsigned FracBits = LogitFracBitsDef;
  localparam longint unsigned VocabLimit = MaxVocabDef;
  localparam longint unsigned UnitQ18 = 64'd262144;
  localparam longint unsigned SumCeil = 64'hF_FFFF_FFFF;
  localparam longint LogProbFloor = -64'sd8388608;

  // 2^(-i/16) in Q.18
  localparam longint unsigned Pow2Q18 [17] = '{
    262144, 251030, 240387, 230195, 220436, 211090, 202141, 193571,
    185364, 177505, 169979, 162773, 155872, 149263, 142935, 136875, 131072
  };

  // per-vector scoring state
  longint          vec_max;
  longint unsigned vec_best;
  longint unsigned vec_sum;
  longint unsigned vec_count;
  longint          vec_target_logit;
  bit              vec_target_seen;

  out_beat_t score_q[$];

  // exp(-m) with m >= 0 in Q.F, result in Q.18
  function automatic longint unsigned exp_neg_q18(longint unsigned m);
    longint unsigned u, k, f, i, r, a, b, v;
    u = (m * 64'd94548 + (64'd1 << (FracBits - 1))) >> FracBits;
    k = u >> 16;
    f = u & 64'hFFFF;
    i = f >> 12;
    r = f & 64'hFFF;
    a = Pow2Q18[i];
    b = Pow2Q18[i + 1];
    v = a - (((a - b) * r + 64'd2048) >> 12);
    if (k == 0) return v;
    if (k >= 20) return 0;
    return (v + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic longint unsigned clip_sum(longint unsigned s);
    return (s > SumCeil) ? SumCeil : s;
  endfunction

  // natural log of a Q18.18 sum, returned in Q.F
  function automatic longint ln_sum_q(longint unsigned s);
    longint unsigned y, lg, ln;
    int lead;
    lead = 0;
    if (s < UnitQ18) s = UnitQ18;
    for (int j = 0; j < 64; j++) if (s[j]) lead = j;
    y = (lead >= 30) ? (s >> (lead - 30)) : (s << (30 - lead));
    lg = longint'(lead - 18) << 16;
    for (int j = 15; j >= 0; j--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        lg |= 64'd1 << j;
        y >>= 1;
      end
    end
    ln = (lg * 64'd45426 + 64'd32768) >> 16;
    if (FracBits >= 16) ln <<= (FracBits - 16);
    else ln = (ln + (64'd1 << (15 - FracBits))) >> (16 - FracBits);
    return longint'(ln);
  endfunction

  task automatic clear_vector();
    vec_max = 0;
    vec_best = 0;
    vec_sum = 0;
    vec_count = 0;
    vec_target_logit = 0;
    vec_target_seen = 0;
  endtask

  // fold one element into the vector, queue a result on the last one
  task automatic score_element(in_beat_t b);
    longint x;
    longint lp;
    out_beat_t res;
    x = longint'(b.logit_value);
    if (vec_count < VocabLimit) begin
      if (vec_count == 0) begin
        vec_max = x;
        vec_best = 0;
        vec_sum = UnitQ18;
      end else if (x > vec_max) begin
        vec_sum = clip_sum(((vec_sum * exp_neg_q18(longint'(x - vec_max)) +
                             (UnitQ18 >> 1)) >> 18) + UnitQ18);
        vec_max = x;
        vec_best = vec_count;
      end else begin
        vec_sum = clip_sum(vec_sum + exp_neg_q18(longint'(vec_max - x)));
      end
      if (vec_count == longint'(b.target_index)) begin
        vec_target_logit = x;
        vec_target_seen = 1;
      end
      vec_count++;
    end
    if (b.last_logit) begin
      if (vec_target_seen && vec_count > 0) begin
        lp = vec_target_logit - vec_max - ln_sum_q(vec_sum);
        if (lp < LogProbFloor) lp = LogProbFloor;
        if (lp > 0) lp = 0;
      end else begin
        lp = LogProbFloor;
      end
      res.log_prob = lp[LogitW-1:0];
      res.greedy_index = vec_best[IndexW-1:0];
      res.target_found = vec_target_seen;
      score_q.insert(score_q.size(), res);
      clear_vector();
    end
  endtask

  assign pending_o = score_q.size();

  // watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      clear_vector();
      score_q.delete();
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) score_element(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (score_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result beat %p", out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = score_q.pop_front();
          if (want.log_prob !== out_data_i.log_prob ||
              want.greedy_index !== out_data_i.greedy_index ||
              want.target_found !== out_data_i.target_found) begin
            if (errors_o < 10)
              $display({"result %0d: expected lp %0d idx %0d found %0d, ",
                        "got lp %0d idx %0d found %0d"},
                       results_o, want.log_prob, want.greedy_index, want.target_found,
                       out_data_i.log_prob, out_data_i.greedy_index, out_data_i.target_found);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/tb_log_softmax_argmax_scorer.sv @@
// tb_log_softmax_argmax_scorer: drives logit vectors into the scorer with random gaps
// and output stalls; checking is done by lsa_score_check
// depends on lsa_pkg, log_softmax_argmax_scorer and lsa_score_check
module tb_log_softmax_argmax_scorer;
  timeunit 1ns;
  timeprecision 1ps;

  import lsa_pkg::*;

  localparam int CycleLimit = 600000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  int errors;
  int pending;
  int results;
  int beats_sent;
  int vectors_sent;
  int cycles = 0;
  bit calm;

  log_softmax_argmax_scorer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  lsa_score_check u_check (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // random stall on the result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 29);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // send one element beat, with an occasional random gap before it
  task automatic send_logit(logic signed [LogitW-1:0] logit, logic [IndexW-1:0] tgt,
                            logic last);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{logit_value: logit, target_index: tgt, last_logit: last};
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (last) vectors_sent++;
  endtask

  // one random vector; mode picks spread, clustering or heavy ties
  task automatic send_random_vector();
    int len, mode, base, tgt, t, v;
    len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    mode = $urandom_range(2);
    base = $urandom_range(0, 16777215) - 8388608;
    case ($urandom_range(9))
      0:       tgt = $urandom_range(0, 262143);
      1:       tgt = len;
      default: tgt = $urandom_range(0, len - 1);
    endcase
    for (int i = 0; i < len; i++) begin
      case (mode)
        0:       v = $urandom_range(0, 16777215) - 8388608;
        1:       v = base + $urandom_range(0, 1 << 20) - (1 << 19);
        default: v = base + 65536 * $urandom_range(0, 2);
      endcase
      t = ($urandom_range(9) == 0) ? $urandom_range(0, 262143) : tgt;
      send_logit(v[LogitW-1:0], t[IndexW-1:0], i == len - 1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    calm = 1'b0;
    beats_sent = 0;
    vectors_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single element at the top, single element with target absent
    send_logit(24'sh7FFFFF, 18'd0, 1'b1);
    send_logit(24'sh800000, 18'd1, 1'b1);
    // extreme spread saturates the result, tie keeps the earlier index
    send_logit(24'sh800000, 18'd0, 1'b0);
    send_logit(24'sh7FFFFF, 18'd0, 1'b0);
    send_logit(24'sh7FFFFF, 18'd0, 1'b1);
    // all equal logits
    for (int i = 0; i < 4; i++) send_logit(24'sd5, 18'd3, i == 3);
    // target changes from element to element
    send_logit(24'sd1000, 18'd5, 1'b0);
    send_logit(24'sd2000, 18'd1, 1'b0);
    send_logit(24'sd3000, 18'd7, 1'b1);
    // top target index, never reached
    send_logit(-24'sd70000, 18'h3FFFF, 1'b0);
    send_logit(24'sd65536, 18'h3FFFF, 1'b0);
    send_logit(24'sd0, 18'h3FFFF, 1'b1);
    // logits falling then rising to a new maximum, target below the maximum
    send_logit(24'sd0, 18'd2, 1'b0);
    send_logit(-24'sd131072, 18'd2, 1'b0);
    send_logit(-24'sd1, 18'd2, 1'b0);
    send_logit(24'sd196608, 18'd2, 1'b1);

    // random vectors, with a stretch of no gaps or stalls
    while (beats_sent < 2000) begin
      calm = (beats_sent > 900 && beats_sent < 1200);
      send_random_vector();
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("sent %0d logit beats in %0d vectors, checked %0d results",
             beats_sent, vectors_sent, results);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/lsa_pkg.sv
sv/lsa_mul.sv
sv/log_softmax_argmax_scorer.sv
sv/lsa_check.sv
test/lsa_check.sv
test/tb_log_softmax_argmax_scorer.sv
